### hw/rtl/smsel_pkg.sv
// -----------------------------------------------------------------------------
// smsel_pkg: shared types and constants for the stream median selector
// Sizes of the sorted store, the controller states and the command and
// status groups between controller and datapath.
// -----------------------------------------------------------------------------
package smsel_pkg;

	localparam int DEPTH   = 64;
	localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W   = $clog2(DEPTH + 1);
	localparam int VALUE_W = 32;
	localparam int COUNT_W = 7;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECIDE,
		ST_CMP,
		ST_PLACE,
		ST_POST,
		ST_SEL,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic load;
		logic drop;
		logic rd_prev;
		logic rd_next;
		logic shift;
		logic place;
		logic rd_mid;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic pos_zero;
		logic pos_one;
		logic greater;
		logic last;
		logic out_busy;
	} sts_t;

endpackage

### hw/rtl/smsel_ctrl.sv
// -----------------------------------------------------------------------------
// smsel_ctrl: sequencer for the stream median selector
// Steps each item through the insertion loop and, after the last item of a
// run, through the median read and result hand-off.
// -----------------------------------------------------------------------------
module smsel_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  smsel_pkg::sts_t   sts,
	output smsel_pkg::cmd_t   cmd
);

	smsel_pkg::state_t state_q;
	smsel_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= smsel_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			smsel_pkg::ST_IDLE: begin
				if (in_valid) state_d = smsel_pkg::ST_DECIDE;
			end
			smsel_pkg::ST_DECIDE: begin
				priority if (sts.full) begin
					state_d = sts.last ? smsel_pkg::ST_SEL : smsel_pkg::ST_IDLE;
				end else if (sts.pos_zero) begin
					state_d = smsel_pkg::ST_POST;
				end else begin
					state_d = smsel_pkg::ST_CMP;
				end
			end
			smsel_pkg::ST_CMP: begin
				priority if (!sts.greater) begin
					state_d = smsel_pkg::ST_POST;
				end else if (sts.pos_one) begin
					state_d = smsel_pkg::ST_PLACE;
				end else begin
					state_d = smsel_pkg::ST_CMP;
				end
			end
			smsel_pkg::ST_PLACE: begin
				state_d = smsel_pkg::ST_POST;
			end
			smsel_pkg::ST_POST: begin
				state_d = sts.last ? smsel_pkg::ST_SEL : smsel_pkg::ST_IDLE;
			end
			smsel_pkg::ST_SEL: begin
				if (!sts.out_busy) state_d = smsel_pkg::ST_EMIT;
			end
			smsel_pkg::ST_EMIT: begin
				state_d = smsel_pkg::ST_IDLE;
			end
			default: begin
				state_d = smsel_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			smsel_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			smsel_pkg::ST_DECIDE: begin
				priority if (sts.full) begin
					cmd.drop = 1'b1;
				end else if (sts.pos_zero) begin
					cmd.place = 1'b1;
				end else begin
					cmd.rd_prev = 1'b1;
				end
			end
			smsel_pkg::ST_CMP: begin
				if (sts.greater) begin
					cmd.shift   = 1'b1;
					cmd.rd_next = !sts.pos_one;
				end else begin
					cmd.place = 1'b1;
				end
			end
			smsel_pkg::ST_PLACE: begin
				cmd.place = 1'b1;
			end
			smsel_pkg::ST_POST: begin
			end
			smsel_pkg::ST_SEL: begin
				cmd.rd_mid = !sts.out_busy;
			end
			smsel_pkg::ST_EMIT: begin
				cmd.emit = 1'b1;
			end
			default: begin
			end
		endcase
	end

endmodule

### hw/rtl/smsel_dp.sv
// -----------------------------------------------------------------------------
// smsel_dp: datapath for the stream median selector
// Sorted store, insertion position, kept count, drop flag and the output
// register that holds a finished result until it is taken.
// -----------------------------------------------------------------------------
module smsel_dp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  smsel_pkg::cmd_t                     cmd,
	output smsel_pkg::sts_t                     sts,
	input  logic signed [smsel_pkg::VALUE_W-1:0] value,
	input  logic                                last,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [smsel_pkg::VALUE_W-1:0] median,
	output logic        [smsel_pkg::COUNT_W-1:0] count,
	output logic                                overflow
);

	logic [smsel_pkg::VALUE_W-1:0] mem [smsel_pkg::DEPTH];

	logic signed [smsel_pkg::VALUE_W-1:0] value_q;
	logic                                 last_q;
	logic        [smsel_pkg::VALUE_W-1:0] rd_data_q;
	logic        [smsel_pkg::CNT_W-1:0]   pos_q;
	logic        [smsel_pkg::CNT_W-1:0]   count_q;
	logic                                 drop_q;
	logic                                 out_valid_q;
	logic signed [smsel_pkg::VALUE_W-1:0] median_q;
	logic        [smsel_pkg::COUNT_W-1:0] count_out_q;
	logic                                 overflow_q;

	logic [smsel_pkg::ADDR_W-1:0] rd_addr;
	logic [smsel_pkg::ADDR_W-1:0] wr_addr;
	logic [smsel_pkg::VALUE_W-1:0] wr_data;
	logic                          rd_en;
	logic                          wr_en;

	always_comb begin
		priority if (cmd.rd_mid) begin
			rd_addr = smsel_pkg::ADDR_W'(count_q >> 1);
		end else if (cmd.rd_next) begin
			rd_addr = smsel_pkg::ADDR_W'(pos_q - smsel_pkg::CNT_W'(2));
		end else begin
			rd_addr = smsel_pkg::ADDR_W'(pos_q - smsel_pkg::CNT_W'(1));
		end
	end

	assign rd_en   = cmd.rd_mid | cmd.rd_next | cmd.rd_prev;
	assign wr_en   = cmd.shift | cmd.place;
	assign wr_addr = smsel_pkg::ADDR_W'(pos_q);
	assign wr_data = cmd.shift ? rd_data_q : value_q;

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		if (rd_en) rd_data_q <= mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			value_q <= value;
			last_q  <= last;
		end
		if (cmd.emit) begin
			median_q    <= rd_data_q;
			count_out_q <= smsel_pkg::COUNT_W'(count_q);
			overflow_q  <= drop_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			count_q     <= '0;
			drop_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				pos_q <= count_q;
			end else if (cmd.shift) begin
				pos_q <= pos_q - smsel_pkg::CNT_W'(1);
			end else if (cmd.emit) begin
				pos_q <= '0;
			end
			if (cmd.drop) drop_q <= 1'b1;
			if (cmd.place) count_q <= count_q + smsel_pkg::CNT_W'(1);
			if (cmd.emit) begin
				count_q     <= '0;
				drop_q      <= 1'b0;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		sts.full     = (count_q == smsel_pkg::CNT_W'(smsel_pkg::DEPTH));
		sts.pos_zero = (pos_q == '0);
		sts.pos_one  = (pos_q == smsel_pkg::CNT_W'(1));
		sts.greater  = ($signed(rd_data_q) > value_q);
		sts.last     = last_q;
		sts.out_busy = out_valid_q;
	end

	assign out_valid = out_valid_q;
	assign median    = median_q;
	assign count     = count_out_q;
	assign overflow  = overflow_q;

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= smsel_pkg::CNT_W'(smsel_pkg::DEPTH))
		else $error("kept count beyond store depth");

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= count_q)
		else $error("insertion position beyond kept count");

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> !out_valid_q)
		else $error("result written over a pending result");

	a_emit_clear: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> (count_q == '0) && !drop_q && out_valid_q)
		else $error("run not cleared after result");

	a_place_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.place |-> !sts.full)
		else $error("value placed into a full store");

endmodule

### hw/rtl/stream_median_select.sv
// -----------------------------------------------------------------------------
// stream_median_select: upper median of a run of signed values
// Inserts each item of a run into a sorted store and, after the item marked
// last, returns the element at sorted position count/2 with the count.
// -----------------------------------------------------------------------------
// Each item is inserted into an ascending 64-entry store held in a single
// memory with one write and one registered read per cycle; the insertion
// loop moves one larger entry up per cycle. A new item is accepted only
// after the previous one has been placed or, when the store is full,
// dropped; the last item of a run also waits for the median read, which
// is held while the previous result has not been taken. A result waits in
// an output register, so the next run can start while it is held. Values
// beyond 64 in a run are dropped and the result then carries overflow; the
// store clears itself after every result.
// -----------------------------------------------------------------------------
module stream_median_select (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic signed [smsel_pkg::VALUE_W-1:0] value,
	input  logic                                last,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [smsel_pkg::VALUE_W-1:0] median,
	output logic        [smsel_pkg::COUNT_W-1:0] count,
	output logic                                overflow
);

	smsel_pkg::cmd_t cmd;
	smsel_pkg::sts_t sts;

	smsel_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	smsel_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.value     (value),
		.last      (last),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.median    (median),
		.count     (count),
		.overflow  (overflow)
	);

endmodule
